/* rtl/core/rtps_pkg.sv */
`timescale 1ns / 1ps
// Package for the rank tercile pivot select block: sizes, sequencer states, helpers.
package rtps_pkg;

	localparam int MaxItems = 64;
	localparam int AddrW    = $clog2(MaxItems);
	localparam int CntW     = 7;
	localparam int DataW    = 32;

	typedef logic signed [DataW-1:0] data_t;
	typedef logic [CntW-1:0]         cnt_t;
	typedef logic [AddrW-1:0]        addr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PIV,
		ST_CAP,
		ST_SWEEP,
		ST_DRAIN,
		ST_TALLY,
		ST_DONE
	} rtps_state_t;

	// n/3 as (n*43)>>7, exact for n up to 127
	function automatic cnt_t third_of(input cnt_t n);
		logic [12:0] p;
		p = {6'd0, n} * 13'd43;
		return {1'b0, p[12:7]};
	endfunction

endpackage

/* rtl/core/rtps_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for input items and result items.
interface rtps_in_if;
	import rtps_pkg::*;
	logic  valid;
	logic  ready;
	data_t value;
	logic  last;

	modport source (output valid, output value, output last, input ready);
	modport sink   (input valid, input value, input last, output ready);
endinterface

interface rtps_out_if;
	import rtps_pkg::*;
	logic  valid;
	logic  ready;
	data_t small_value;
	logic  small_found;
	data_t big_value;
	logic  big_found;
	cnt_t  element_count;
	logic  overflow;

	modport source (output valid, output small_value, output small_found,
		output big_value, output big_found, output element_count, output overflow,
		input ready);
	modport sink   (input valid, input small_value, input small_found,
		input big_value, input big_found, input element_count, input overflow,
		output ready);
endinterface

/* rtl/core/rank_tercile_pivot_select.sv */
`timescale 1ns / 1ps
// Top level: two-pivot selection by rank count over a stored set of signed values.
// Values stream in one item per cycle while idle and are written to a 64-entry store; a
// value arriving when the store is full is dropped and the set is flagged as overflowed.
// The item with last set closes the set (even if its own value was dropped). The block
// then ranks every kept value (rank = number of kept values strictly smaller) using one
// memory read port and one signed comparator: for each of the n values it reads the
// pivot, captures it, sweeps all n entries, drains the last compare and tallies. No new
// item is accepted until the result is loaded. The result reports the value of rank n/3
// and of rank 2*(n/3); the upper one only when the two ranks differ. A missing rank
// (duplicates) reports found = 0 and value 0. The result sits in an output register, so
// new items are accepted while it waits to be taken; only the final load of the next
// result waits for that register to empty.
module rank_tercile_pivot_select (
	input  logic        clk,
	input  logic        arst_n,
	rtps_in_if.sink     item_in,
	rtps_out_if.source  result_out
);
	import rtps_pkg::*;

	rtps_state_t state_q, state_d;

	// element store
	data_t mem [MaxItems];
	data_t rd_data_q;
	addr_t rd_addr;
	logic  mem_we;

	// set bookkeeping
	cnt_t fill_q;
	cnt_t set_count_q;
	logic dropped_q;
	logic set_drop_q;

	// ranking sequencer
	addr_t i_q;
	addr_t k_q;
	data_t pivot_q;
	cnt_t  rank_q;
	logic  issue_s1;
	cnt_t  lo_rank;
	cnt_t  hi_rank;
	logic  last_i;
	logic  last_k;

	// working result
	data_t small_v_q;
	logic  small_f_q;
	data_t big_v_q;
	logic  big_f_q;

	// output register
	logic  out_vld_q;
	data_t out_small_v_q;
	logic  out_small_f_q;
	data_t out_big_v_q;
	logic  out_big_f_q;
	cnt_t  out_count_q;
	logic  out_ovf_q;

	logic accept;
	logic store_ok;
	logic done_go;

	assign accept   = item_in.valid && item_in.ready;
	assign store_ok = fill_q < cnt_t'(MaxItems);
	assign lo_rank  = third_of(set_count_q);
	assign hi_rank  = {lo_rank[CntW-2:0], 1'b0};
	assign last_i   = {1'b0, i_q} == (set_count_q - cnt_t'(1));
	assign last_k   = {1'b0, k_q} == (set_count_q - cnt_t'(1));
	assign done_go  = !out_vld_q || result_out.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (accept && item_in.last) state_d = ST_PIV;
			ST_PIV:   state_d = ST_CAP;
			ST_CAP:   state_d = ST_SWEEP;
			ST_SWEEP: if (last_k) state_d = ST_DRAIN;
			ST_DRAIN: state_d = ST_TALLY;
			ST_TALLY: state_d = last_i ? ST_DONE : ST_PIV;
			ST_DONE:  if (done_go) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		item_in.ready = 1'b0;
		rd_addr       = '0;
		unique case (state_q)
			ST_IDLE:  item_in.ready = 1'b1;
			ST_PIV:   rd_addr = i_q;
			ST_SWEEP: rd_addr = k_q;
			default:  rd_addr = '0;
		endcase
	end

	assign mem_we = accept && store_ok;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[fill_q[AddrW-1:0]] <= item_in.value;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			set_count_q <= '0;
			dropped_q   <= 1'b0;
			set_drop_q  <= 1'b0;
			i_q         <= '0;
			k_q         <= '0;
			rank_q      <= '0;
			issue_s1    <= 1'b0;
			small_f_q   <= 1'b0;
			big_f_q     <= 1'b0;
			out_vld_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			issue_s1 <= (state_q == ST_SWEEP);

			if (accept) begin
				if (item_in.last) begin
					// close the set; the store is emptied once the result is loaded
					set_count_q <= store_ok ? fill_q + cnt_t'(1) : fill_q;
					set_drop_q  <= dropped_q || !store_ok;
					fill_q      <= store_ok ? fill_q + cnt_t'(1) : fill_q;
					dropped_q   <= dropped_q || !store_ok;
					i_q         <= '0;
					small_f_q   <= 1'b0;
					big_f_q     <= 1'b0;
				end else if (store_ok) begin
					fill_q <= fill_q + cnt_t'(1);
				end else begin
					dropped_q <= 1'b1;
				end
			end

			if (state_q == ST_CAP) begin
				k_q    <= '0;
				rank_q <= '0;
			end
			if (state_q == ST_SWEEP) begin
				k_q <= k_q + addr_t'(1);
			end
			if (issue_s1 && (rd_data_q < pivot_q)) begin
				rank_q <= rank_q + cnt_t'(1);
			end

			if (state_q == ST_TALLY) begin
				i_q <= i_q + addr_t'(1);
				if (rank_q == lo_rank) begin
					small_f_q <= 1'b1;
				end else if (rank_q == hi_rank) begin
					big_f_q <= 1'b1;
				end
			end

			// a load in the same cycle as a take keeps the register full
			if (state_q == ST_DONE && done_go) begin
				out_vld_q <= 1'b1;
				fill_q    <= '0;
				dropped_q <= 1'b0;
			end else if (result_out.valid && result_out.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == ST_CAP) begin
			pivot_q <= rd_data_q;
		end
		if (accept && item_in.last) begin
			small_v_q <= '0;
			big_v_q   <= '0;
		end
		if (state_q == ST_TALLY) begin
			if (rank_q == lo_rank) begin
				small_v_q <= pivot_q;
			end else if (rank_q == hi_rank) begin
				big_v_q <= pivot_q;
			end
		end
		if (state_q == ST_DONE && done_go) begin
			out_small_v_q <= small_v_q;
			out_small_f_q <= small_f_q;
			out_big_v_q   <= big_v_q;
			out_big_f_q   <= big_f_q;
			out_count_q   <= set_count_q;
			out_ovf_q     <= set_drop_q;
		end
	end

	assign result_out.valid         = out_vld_q;
	assign result_out.small_value   = out_small_v_q;
	assign result_out.small_found   = out_small_f_q;
	assign result_out.big_value     = out_big_v_q;
	assign result_out.big_found     = out_big_f_q;
	assign result_out.element_count = out_count_q;
	assign result_out.overflow      = out_ovf_q;

`ifndef SYNTHESIS
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cnt_t'(MaxItems))
		else $error("fill count beyond store capacity");

	a_rank_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_TALLY |-> rank_q < set_count_q)
		else $error("rank not below set size");

	a_big_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_big_f_q) |-> out_count_q >= cnt_t'(3))
		else $error("upper pivot reported with equal pivot ranks");

	a_set_emptied: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && done_go) |=> (fill_q == '0 && !dropped_q))
		else $error("set not emptied after result load");
`endif

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for rank_tercile_pivot_select: random sets, rank-count pivot predictor, scoreboard.
module tb_top;
	import rtps_pkg::*;

	// Worst quiet stretch is one closing item at n = 64, plus a full result-side
	// stall and a send gap. Take it several times over.
	localparam int WatchdogLimit = 30000;
	localparam int DrainCycles   = 20;
	localparam int ItemTarget    = 1200;
	localparam int PrintCap      = 50;

	typedef struct {
		data_t value;
		logic  last;
	} elem_item_t;

	typedef struct {
		data_t small_value;
		logic  small_found;
		data_t big_value;
		logic  big_found;
		cnt_t  element_count;
		logic  overflow;
	} pivot_result_t;

	logic clk;
	logic arst_n;

	rtps_in_if  item_in ();
	rtps_out_if result_out ();

	rank_tercile_pivot_select DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_in   (item_in),
		.result_out(result_out)
	);

	// Predictor copy of the set being loaded.
	data_t set_store [MaxItems];
	int    set_fill;
	logic  set_dropped;

	elem_item_t    stim_items[$];      // items still to be sent
	pivot_result_t pivots_expected[$]; // pivot results still owed by the block
	int            error_count;

	// Handshake bookkeeping: fire flags are taken at the rising edge and
	// read by the drivers at the following falling edge.
	logic in_fire;
	logic out_fire;
	int   send_gap, send_burst;
	int   recv_gap, recv_burst;
	int   quiet_cycles;

	always #4 clk = ~clk;

	// Kept values go into the store; once full, values are dropped and the set
	// is marked. A closing item (even a dropped one) ranks all kept values and
	// yields one result, then empties the set.
	function automatic bit predict_pivots(input data_t v, input logic is_last,
		output pivot_result_t res);
		int n;
		int lo_rank;
		int hi_rank;
		int rank;
		res.small_value   = '0;
		res.small_found   = 1'b0;
		res.big_value     = '0;
		res.big_found     = 1'b0;
		res.element_count = '0;
		res.overflow      = 1'b0;
		if (set_fill < MaxItems) begin
			set_store[set_fill] = v;
			set_fill++;
		end else begin
			set_dropped = 1'b1;
		end
		if (!is_last)
			return 1'b0;
		n       = set_fill;
		lo_rank = n / 3;
		hi_rank = lo_rank * 2;
		for (int i = 0; i < n; i++) begin
			rank = 0;
			for (int k = 0; k < n; k++)
				if (set_store[k] < set_store[i])
					rank++;
			// equal ranks (n < 3): only the lower pivot is reported
			if (rank == lo_rank) begin
				res.small_value = set_store[i];
				res.small_found = 1'b1;
			end else if (rank == hi_rank) begin
				res.big_value = set_store[i];
				res.big_found = 1'b1;
			end
		end
		res.element_count = cnt_t'(n);
		res.overflow      = set_dropped;
		set_fill    = 0;
		set_dropped = 1'b0;
		return 1'b1;
	endfunction

	task automatic report_mismatch(input string msg);
		if (error_count < PrintCap)
			$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Per-item wait: uniformly drawn, with occasional back-to-back bursts.
	function automatic int draw_wait(inout int burst);
		if (burst > 0) begin
			burst--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			burst = $urandom_range(20, 80);
			return 0;
		end
		return $urandom_range(0, 10);
	endfunction

	// Value mixes: full random bits, a narrow band that forces duplicates
	// (and with them missing ranks), and the field extremes.
	function automatic data_t pick_value(input int mode);
		case (mode)
			0: return data_t'($urandom);
			1: return data_t'($signed($urandom_range(0, 6)) - 3);
			default: begin
				case ($urandom_range(0, 4))
					0: return 32'sh8000_0000;
					1: return 32'sh7FFF_FFFF;
					2: return 32'sh0000_0000;
					3: return -32'sd1;
					default: return data_t'($urandom);
				endcase
			end
		endcase
	endfunction

	task automatic push_elem(input data_t v, input logic is_last);
		elem_item_t it;
		it.value = v;
		it.last  = is_last;
		stim_items.push_back(it);
	endtask

	// Input side: run the predictor on every accepted item.
	always @(posedge clk or negedge arst_n) begin : accept_items
		pivot_result_t res;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= item_in.valid && item_in.ready;
			if (item_in.valid && item_in.ready)
				if (predict_pivots(item_in.value, item_in.last, res))
					pivots_expected.push_back(res);
		end
	end

	// Item driver: holds an item until taken, then waits its drawn gap.
	always @(negedge clk) begin : drive_items
		elem_item_t it;
		if (!arst_n) begin
			item_in.valid <= 1'b0;
		end else if (!item_in.valid || in_fire) begin
			if (send_gap > 0) begin
				item_in.valid <= 1'b0;
				send_gap--;
			end else if (stim_items.size() > 0) begin
				it = stim_items.pop_front();
				item_in.value <= it.value;
				item_in.last  <= it.last;
				item_in.valid <= 1'b1;
				send_gap = draw_wait(send_burst);
			end else begin
				item_in.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : note_results
		if (!arst_n)
			out_fire <= 1'b0;
		else
			out_fire <= result_out.valid && result_out.ready;
	end

	// Result side ready: after each taken result a new stall is drawn. The
	// countdown runs whether or not a result is waiting, so stalls land on
	// every phase of the ranking work.
	always @(negedge clk) begin : drive_ready
		if (!arst_n) begin
			result_out.ready <= 1'b0;
		end else begin
			if (out_fire)
				recv_gap = draw_wait(recv_burst);
			if (recv_gap > 0) begin
				result_out.ready <= 1'b0;
				recv_gap--;
			end else begin
				result_out.ready <= 1'b1;
			end
		end
	end

	// Scoreboard: each taken result against the oldest expectation.
	always @(posedge clk) begin : check_results
		pivot_result_t want;
		if (arst_n && result_out.valid && result_out.ready) begin
			if (pivots_expected.size() == 0) begin
				report_mismatch("result with no expectation waiting");
			end else begin
				want = pivots_expected.pop_front();
				if (result_out.small_value !== want.small_value)
					report_mismatch($sformatf("small_value got %0d expected %0d",
						result_out.small_value, want.small_value));
				if (result_out.small_found !== want.small_found)
					report_mismatch($sformatf("small_found got %b expected %b",
						result_out.small_found, want.small_found));
				if (result_out.big_value !== want.big_value)
					report_mismatch($sformatf("big_value got %0d expected %0d",
						result_out.big_value, want.big_value));
				if (result_out.big_found !== want.big_found)
					report_mismatch($sformatf("big_found got %b expected %b",
						result_out.big_found, want.big_found));
				if (result_out.element_count !== want.element_count)
					report_mismatch($sformatf("element_count got %0d expected %0d",
						result_out.element_count, want.element_count));
				if (result_out.overflow !== want.overflow)
					report_mismatch($sformatf("overflow got %b expected %b",
						result_out.overflow, want.overflow));
			end
		end
	end

	// Watchdog: any handshake restarts the count.
	always @(posedge clk) begin : watchdog
		if (!arst_n || (item_in.valid && item_in.ready) ||
			(result_out.valid && result_out.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WatchdogLimit) begin
			$display("[%0t] watchdog: no handshake for %0d cycles", $time, quiet_cycles);
			$display("Regression FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : run
		int kept;
		int set_len;
		int pick;
		int mode;
		int set_idx;
		clk              = 1'b0;
		arst_n           = 1'b0;
		item_in.valid    = 1'b0;
		item_in.value    = '0;
		item_in.last     = 1'b0;
		result_out.ready = 1'b0;
		set_fill         = 0;
		set_dropped      = 1'b0;
		error_count      = 0;
		send_gap         = 0;
		send_burst       = 0;
		recv_gap         = 0;
		recv_burst       = 0;
		quiet_cycles     = 0;

		// Directed sets.
		// single element: both pivot ranks are 0, only the lower one reported
		push_elem(32'sh8000_0000, 1'b1);
		// two elements, extremes: ranks still equal
		push_elem(32'sh7FFF_FFFF, 1'b0);
		push_elem(32'sh8000_0000, 1'b1);
		// three distinct: both pivots found
		push_elem(32'sh0000_0000, 1'b0);
		push_elem(-32'sd1, 1'b0);
		push_elem(32'sd1, 1'b1);
		// all duplicates: ranks 1 and 2 belong to nobody
		push_elem(32'sd5, 1'b0);
		push_elem(32'sd5, 1'b0);
		push_elem(32'sd5, 1'b1);
		// six values across the whole range
		push_elem(32'sh8000_0000, 1'b0);
		push_elem(32'sh7FFF_FFFF, 1'b0);
		push_elem(-32'sd1, 1'b0);
		push_elem(32'sh0000_0000, 1'b0);
		push_elem(32'sd1, 1'b0);
		push_elem(32'sd2, 1'b1);
		// duplicates: lower pivot shared by several holders, upper rank missing
		push_elem(32'sd4, 1'b0);
		push_elem(32'sd4, 1'b0);
		push_elem(32'sd4, 1'b0);
		push_elem(32'sd4, 1'b0);
		push_elem(32'sd1, 1'b1);

		// Random sets: mostly short; a few full stores and overflowed ones,
		// where the closing item itself is dropped.
		kept    = 0;
		set_idx = 0;
		while (kept < ItemTarget) begin
			pick = $urandom_range(0, 99);
			if (set_idx == 0 || (pick >= 5 && pick < 10))
				set_len = $urandom_range(MaxItems + 1, MaxItems + 8);
			else if (set_idx == 1 || pick < 5)
				set_len = MaxItems;
			else if (pick < 16)
				set_len = $urandom_range(21, MaxItems - 1);
			else
				set_len = $urandom_range(1, 20);
			mode = $urandom_range(0, 2);
			for (int j = 0; j < set_len; j++)
				push_elem(pick_value(mode), j == set_len - 1);
			kept += (set_len < MaxItems) ? set_len : MaxItems;
			set_idx++;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (stim_items.size() != 0 || item_in.valid || pivots_expected.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

/* rank_tercile_pivot_select.f */
rtl/core/rtps_pkg.sv
rtl/core/rtps_if.sv
rtl/core/rank_tercile_pivot_select.sv
tb/tb_top.sv
